// ----- rtl/core/gqr_pkg.sv -----
package gqr_pkg;

    // Fixed word width of every matrix element.
    localparam int DATA_W = 32;

    // The square root yields one root bit per step over a 64-bit radicand.
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W     = 5;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT_Q,
        ST_COL,
        ST_RD_A,
        ST_RD_B,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_C,
        ST_SQRT,
        ST_DIV_C,
        ST_DIV_S,
        ST_RD_X,
        ST_RD_Y,
        ST_MUL_CX,
        ST_MUL_SY,
        ST_MUL_SX,
        ST_MUL_CY,
        ST_ACC_Y,
        ST_WR_Y,
        ST_ZERO,
        ST_NEXT_ROW,
        ST_NEG_CHK,
        ST_NEG_R,
        ST_NEG_Q,
        ST_NEG_NEXT,
        ST_EMIT
    } gqr_state_t;

    // Which factor a rotation or an emitted word refers to.
    typedef enum logic {
        MAT_R = 1'b0,
        MAT_Q = 1'b1
    } gqr_mat_t;

endpackage

// ----- rtl/core/givens_qr_decomposition.sv -----
// Loading: one input word per cycle; in_stall is low only while no decomposition runs.
// The final word starts it: Q is set to the identity, then each column is swept; a rotation
// whose b is zero is skipped, a nonzero one runs the bit-serial square root, the restoring
// divider and the single shared 33x33 multiplier. Sign fix negates each R row with a negative
// diagonal and its Q column; then 2*n*n words, R before Q, one a cycle while out_stall is low.
// Asynchronous active-low reset clears the sequencer and load count, and sets dim_reg to 4.
module givens_qr_decomposition
    import gqr_pkg::*;
#(
    parameter int MAX_DIM   = 4,
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] in_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               which_matrix,
    output logic [1:0]         row_index,
    output logic [1:0]         col_index,
    output logic signed [31:0] out_value,
    output logic               last
);

    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int IDX_W   = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int QUOT_W  = FRAC_BITS + 1;
    localparam int COEF_W  = FRAC_BITS + 2;
    localparam int ACC_W   = 67;
    localparam int ADDR_TW = 2 * DIM_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 67'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -67'sd2147483648;
    localparam logic [DATA_W-1:0]       ONE_FX  = DATA_W'(64'd1 << FRAC_BITS);

    // Linear position of a cell for the current dimension.
    function automatic logic [IDX_W-1:0] cell_addr(input logic [DIM_W-1:0] row,
                                                   input logic [DIM_W-1:0] col,
                                                   input logic [DIM_W-1:0] dim);
        logic [ADDR_TW-1:0] t;
        t = ADDR_TW'(row) * ADDR_TW'(dim) + ADDR_TW'(col);
        return t[IDX_W-1:0];
    endfunction

    // Floor shift of the accumulator, then saturation to a word.
    function automatic logic [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sh;
        sh = v >>> FRAC_BITS;
        if (sh > ACC_MAX) return 32'h7fff_ffff;
        if (sh < ACC_MIN) return 32'h8000_0000;
        return sh[DATA_W-1:0];
    endfunction

    // Negation that maps the most negative word to the most positive one.
    function automatic logic [DATA_W-1:0] neg_sat(input logic [DATA_W-1:0] v);
        if (v == 32'h8000_0000) return 32'h7fff_ffff;
        return DATA_W'(-v);
    endfunction

    // Control registers.
    gqr_state_t       state_reg, state_next;
    gqr_mat_t         tgt_reg, tgt_next;
    logic [DIM_W-1:0] ic_reg, ic_next, jc_reg, jc_next, kc_reg, kc_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [2:0]       dim_reg;
    logic             out_valid_reg;

    // Datapath registers.
    logic signed [DATA_W-1:0] a_reg, b_reg, vx_reg, vy_reg;
    logic signed [65:0]       prod_reg;
    logic [63:0]              rad_reg;
    logic [34:0]              sq_rem_reg;
    logic [31:0]              root_reg;
    logic [33:0]              div_rem_reg;
    logic [QUOT_W-1:0]        quot_reg;
    logic signed [COEF_W-1:0] c_reg, s_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DATA_W-1:0]        r_mem_reg [CELLS];
    logic [DATA_W-1:0]        q_mem_reg [CELLS];
    logic                     which_reg, last_reg;
    logic [1:0]               row_reg, col_reg;
    logic [DATA_W-1:0]        value_reg;

    // Effective dimension, clamped to 1..MAX_DIM.
    logic [DIM_W-1:0] n_eff, n_m1;
    logic [CNT_W-1:0] total;
    always_comb
    begin
        if (dim_reg == 3'd0)
            n_eff = DIM_W'(1);
        else if (int'(dim_reg) > MAX_DIM)
            n_eff = DIM_W'(MAX_DIM);
        else
            n_eff = DIM_W'(dim_reg);
    end
    assign n_m1  = n_eff - DIM_W'(1);
    assign total = CNT_W'(n_eff) * CNT_W'(n_eff);

    logic in_accept, emit_load, ic_last, kc_last, jc_last, load_more;
    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign ic_last   = (ic_reg == n_m1);
    assign kc_last   = (kc_reg == n_m1);
    assign jc_last   = (jc_reg == n_m1);
    assign load_more = ((CNT_W + 1)'(load_count_reg) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(total);

    // Store read port, shared address for both stores.
    logic [IDX_W-1:0]  addr_x, addr_y, rd_addr;
    logic [DATA_W-1:0] r_rd, q_rd, sel_rd;
    assign addr_x = (tgt_reg == MAT_R) ? cell_addr(jc_reg, kc_reg, n_eff)
                                       : cell_addr(kc_reg, jc_reg, n_eff);
    assign addr_y = (tgt_reg == MAT_R) ? cell_addr(ic_reg, kc_reg, n_eff)
                                       : cell_addr(kc_reg, ic_reg, n_eff);
    always_comb
    begin
        case (state_reg)
            ST_RD_A:    rd_addr = cell_addr(jc_reg, jc_reg, n_eff);
            ST_RD_B:    rd_addr = cell_addr(ic_reg, jc_reg, n_eff);
            ST_RD_X:    rd_addr = addr_x;
            ST_RD_Y:    rd_addr = addr_y;
            ST_NEG_CHK: rd_addr = cell_addr(ic_reg, ic_reg, n_eff);
            ST_NEG_R:   rd_addr = cell_addr(ic_reg, kc_reg, n_eff);
            ST_NEG_Q:   rd_addr = cell_addr(kc_reg, ic_reg, n_eff);
            ST_EMIT:    rd_addr = cell_addr(ic_reg, kc_reg, n_eff);
            default:    rd_addr = '0;
        endcase
    end
    assign r_rd   = r_mem_reg[rd_addr];
    assign q_rd   = q_mem_reg[rd_addr];
    assign sel_rd = (tgt_reg == MAT_Q) ? q_rd : r_rd;

    // Shared multiplier with its operand selection.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [32:0] c_ext, s_ext;
    assign c_ext = 33'(c_reg);
    assign s_ext = 33'(s_reg);
    always_comb
    begin
        case (state_reg)
            ST_SQ_A:   begin mul_a = 33'(a_reg);  mul_b = 33'(a_reg);  end
            ST_SQ_B:   begin mul_a = 33'(b_reg);  mul_b = 33'(b_reg);  end
            ST_MUL_CX: begin mul_a = c_ext;       mul_b = 33'(vx_reg); end
            ST_MUL_SY: begin mul_a = s_ext;       mul_b = 33'(vy_reg); end
            ST_MUL_SX: begin mul_a = s_ext;       mul_b = 33'(vx_reg); end
            ST_MUL_CY: begin mul_a = c_ext;       mul_b = 33'(vy_reg); end
            default:   begin mul_a = '0;          mul_b = '0;          end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // One step of the square root: two radicand bits in, one root bit out.
    logic [34:0] sq_trial, sq_shift;
    logic        sq_ge;
    assign sq_shift = {sq_rem_reg[32:0], rad_reg[63:62]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);

    // One step of the restoring divider against the root.
    logic [33:0]       div_diff;
    logic              div_ge;
    logic [QUOT_W-1:0] quot_new;
    logic [32:0]       a_mag, b_mag;
    assign div_ge   = (div_rem_reg >= {2'b00, root_reg});
    assign div_diff = div_ge ? (div_rem_reg - {2'b00, root_reg}) : div_rem_reg;
    assign quot_new = {quot_reg[QUOT_W-2:0], div_ge};
    assign a_mag    = a_reg[31] ? 33'(-33'(a_reg)) : 33'(a_reg);
    assign b_mag    = b_reg[31] ? 33'(-33'(b_reg)) : 33'(b_reg);

    logic signed [COEF_W-1:0] quot_pos, quot_neg;
    assign quot_pos = COEF_W'(quot_new);
    assign quot_neg = -quot_pos;

    logic div_done;
    assign div_done = (step_reg == STEP_W'(FRAC_BITS));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_accept && !load_more) state_next = ST_INIT_Q;
            ST_INIT_Q:   if (ic_last && kc_last) state_next = ST_COL;
            ST_COL:      state_next = jc_last ? ST_NEG_CHK : ST_RD_A;
            ST_RD_A:     state_next = ST_RD_B;
            ST_RD_B:     state_next = (r_rd == '0) ? ST_NEXT_ROW : ST_SQ_A;
            ST_SQ_A:     state_next = ST_SQ_B;
            ST_SQ_B:     state_next = ST_SQ_C;
            ST_SQ_C:     state_next = ST_SQRT;
            ST_SQRT:     if (step_reg == STEP_W'(SQRT_STEPS - 1)) state_next = ST_DIV_C;
            ST_DIV_C:    if (div_done) state_next = ST_DIV_S;
            ST_DIV_S:    if (div_done) state_next = ST_RD_X;
            ST_RD_X:     state_next = ST_RD_Y;
            ST_RD_Y:     state_next = ST_MUL_CX;
            ST_MUL_CX:   state_next = ST_MUL_SY;
            ST_MUL_SY:   state_next = ST_MUL_SX;
            ST_MUL_SX:   state_next = ST_MUL_CY;
            ST_MUL_CY:   state_next = ST_ACC_Y;
            ST_ACC_Y:    state_next = ST_WR_Y;
            ST_WR_Y:
            begin
                if (!kc_last)
                    state_next = ST_RD_X;
                else if (tgt_reg == MAT_R)
                    state_next = ST_ZERO;
                else
                    state_next = ST_NEXT_ROW;
            end
            ST_ZERO:     state_next = ST_RD_X;
            ST_NEXT_ROW: state_next = ic_last ? ST_COL : ST_RD_A;
            ST_NEG_CHK:  state_next = r_rd[31] ? ST_NEG_R : ST_NEG_NEXT;
            ST_NEG_R:    if (kc_last) state_next = ST_NEG_Q;
            ST_NEG_Q:    if (kc_last) state_next = ST_NEG_NEXT;
            ST_NEG_NEXT: state_next = ic_last ? ST_EMIT : ST_NEG_CHK;
            ST_EMIT:
            begin
                if (emit_load && kc_last && ic_last && (tgt_reg == MAT_Q))
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: counters and store writes.
    logic              r_we, q_we;
    logic [IDX_W-1:0]  r_waddr, q_waddr;
    logic [DATA_W-1:0] r_wdata, q_wdata;
    always_comb
    begin
        ic_next         = ic_reg;
        jc_next         = jc_reg;
        kc_next         = kc_reg;
        tgt_next        = tgt_reg;
        step_next       = step_reg;
        load_count_next = load_count_reg;
        r_we            = 1'b0;
        q_we            = 1'b0;
        r_waddr         = addr_x;
        q_waddr         = addr_x;
        r_wdata         = '0;
        q_wdata         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    r_we    = (load_count_reg < total);
                    r_waddr = load_count_reg[IDX_W-1:0];
                    r_wdata = in_value;
                    if (load_more)
                        load_count_next = load_count_reg + CNT_W'(1);
                    else
                    begin
                        load_count_next = '0;
                        ic_next         = '0;
                        kc_next         = '0;
                    end
                end
            end
            ST_INIT_Q:
            begin
                q_we    = 1'b1;
                q_waddr = cell_addr(ic_reg, kc_reg, n_eff);
                q_wdata = (ic_reg == kc_reg) ? ONE_FX : '0;
                if (!kc_last)
                    kc_next = kc_reg + DIM_W'(1);
                else
                begin
                    kc_next = '0;
                    ic_next = ic_reg + DIM_W'(1);
                    jc_next = '0;
                end
            end
            ST_COL:
            begin
                if (jc_last)
                    ic_next = '0;
                else
                    ic_next = jc_reg + DIM_W'(1);
            end
            ST_SQ_C:   step_next = '0;
            ST_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                    step_next = '0;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_DIV_C:  step_next = div_done ? '0 : step_reg + STEP_W'(1);
            ST_DIV_S:
            begin
                step_next = div_done ? '0 : step_reg + STEP_W'(1);
                tgt_next  = MAT_R;
                kc_next   = jc_reg;
            end
            ST_MUL_CY:
            begin
                r_we    = (tgt_reg == MAT_R);
                q_we    = (tgt_reg == MAT_Q);
                r_wdata = sat_acc(acc_reg);
                q_wdata = sat_acc(acc_reg);
            end
            ST_WR_Y:
            begin
                r_we    = (tgt_reg == MAT_R);
                q_we    = (tgt_reg == MAT_Q);
                r_waddr = addr_y;
                q_waddr = addr_y;
                r_wdata = sat_acc(acc_reg);
                q_wdata = sat_acc(acc_reg);
                if (!kc_last)
                    kc_next = kc_reg + DIM_W'(1);
            end
            ST_ZERO:
            begin
                r_we     = 1'b1;
                r_waddr  = cell_addr(ic_reg, jc_reg, n_eff);
                r_wdata  = '0;
                tgt_next = MAT_Q;
                kc_next  = '0;
            end
            ST_NEXT_ROW:
            begin
                if (ic_last)
                    jc_next = jc_reg + DIM_W'(1);
                else
                    ic_next = ic_reg + DIM_W'(1);
            end
            ST_NEG_CHK: kc_next = ic_reg;
            ST_NEG_R:
            begin
                r_we    = 1'b1;
                r_waddr = rd_addr;
                r_wdata = neg_sat(r_rd);
                kc_next = kc_last ? '0 : kc_reg + DIM_W'(1);
            end
            ST_NEG_Q:
            begin
                q_we    = 1'b1;
                q_waddr = rd_addr;
                q_wdata = neg_sat(q_rd);
                if (!kc_last)
                    kc_next = kc_reg + DIM_W'(1);
            end
            ST_NEG_NEXT:
            begin
                if (ic_last)
                begin
                    ic_next  = '0;
                    kc_next  = '0;
                    tgt_next = MAT_R;
                end
                else
                    ic_next = ic_reg + DIM_W'(1);
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    if (!kc_last)
                        kc_next = kc_reg + DIM_W'(1);
                    else
                    begin
                        kc_next = '0;
                        if (!ic_last)
                            ic_next = ic_reg + DIM_W'(1);
                        else
                        begin
                            ic_next  = '0;
                            tgt_next = MAT_Q;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tgt_reg        <= MAT_R;
            ic_reg         <= '0;
            jc_reg         <= '0;
            kc_reg         <= '0;
            step_reg       <= '0;
            load_count_reg <= '0;
            dim_reg        <= 3'd4;
        end
        else
        begin
            state_reg      <= state_next;
            tgt_reg        <= tgt_next;
            ic_reg         <= ic_next;
            jc_reg         <= jc_next;
            kc_reg         <= kc_next;
            step_reg       <= step_next;
            load_count_reg <= load_count_next;
            if (cfg_write_en)
                dim_reg <= cfg_write_data;
        end
    end

    // Element stores.
    always_ff @(posedge clk)
    begin
        if (r_we)
            r_mem_reg[r_waddr] <= r_wdata;
        if (q_we)
            q_mem_reg[q_waddr] <= q_wdata;
    end

    // Arithmetic datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_RD_A: a_reg <= r_rd;
            ST_RD_B: b_reg <= r_rd;
            ST_SQ_B: rad_reg <= prod_reg[63:0];
            ST_SQ_C:
            begin
                rad_reg    <= rad_reg + prod_reg[63:0];
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            ST_SQRT:
            begin
                rad_reg     <= {rad_reg[61:0], 2'b00};
                sq_rem_reg  <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
                root_reg    <= {root_reg[30:0], sq_ge};
                div_rem_reg <= 34'(a_mag);
                quot_reg    <= '0;
            end
            ST_DIV_C:
            begin
                if (div_done)
                begin
                    c_reg       <= a_reg[31] ? quot_neg : quot_pos;
                    div_rem_reg <= 34'(b_mag);
                    quot_reg    <= '0;
                end
                else
                begin
                    div_rem_reg <= {div_diff[32:0], 1'b0};
                    quot_reg    <= quot_new;
                end
            end
            ST_DIV_S:
            begin
                if (div_done)
                    s_reg <= b_reg[31] ? quot_pos : quot_neg;
                else
                begin
                    div_rem_reg <= {div_diff[32:0], 1'b0};
                    quot_reg    <= quot_new;
                end
            end
            ST_RD_X:   vx_reg  <= sel_rd;
            ST_RD_Y:   vy_reg  <= sel_rd;
            ST_MUL_SY: acc_reg <= ACC_W'(prod_reg);
            ST_MUL_SX: acc_reg <= acc_reg - ACC_W'(prod_reg);
            ST_MUL_CY: acc_reg <= ACC_W'(prod_reg);
            ST_ACC_Y:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            default: ;
        endcase
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            which_reg <= tgt_reg;
            row_reg   <= ic_reg[1:0];
            col_reg   <= kc_reg[1:0];
            value_reg <= (tgt_reg == MAT_Q) ? q_rd : r_rd;
            last_reg  <= (tgt_reg == MAT_Q) && ic_last && kc_last;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign which_matrix = which_reg;
    assign row_index    = row_reg;
    assign col_index    = col_reg;
    assign out_value    = value_reg;
    assign last         = last_reg;

endmodule
